// ===== src/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types, constants and helpers for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 32;
    localparam int COUNT_BITS    = 32;
    localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
    localparam int IDX_BITS      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [7:0] WILDCARD_CHAR = 8'h3F;

    typedef logic [7:0]               t_byte;
    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [COUNT_BITS-1:0]    t_count;
    typedef logic [LEN_BITS-1:0]      t_len;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_WILDCARD       = 2'd3
    } t_cfg_reg;

    // one accepted beat as seen by the tracker
    typedef struct packed {
        logic accept;
        logic last;
        logic all_hit;
    } t_step;

    // zero reads as one, anything above the window depth as the depth
    function automatic t_len effective_length(input logic [4:0] len);
        t_len r;
        if (len == 5'd0) begin
            r = t_len'(1);
        end else if (32'(len) > MAX_PATTERN) begin
            r = t_len'(MAX_PATTERN);
        end else begin
            r = t_len'(len);
        end
        return r;
    endfunction

endpackage

// ===== src/wpm_in_if.sv =====
// ----------------------------------------------------------------------------
// wpm_in_if
// Text byte channel: valid/ready with byte and end-of-text flag.
// ----------------------------------------------------------------------------
interface wpm_in_if;
    import wpm_pkg::*;

    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// ===== src/wpm_out_if.sv =====
// ----------------------------------------------------------------------------
// wpm_out_if
// Match result channel: valid/ready with match report and running count.
// ----------------------------------------------------------------------------
interface wpm_out_if;
    import wpm_pkg::*;

    logic   valid;
    logic   ready;
    logic   match_valid;
    t_count match_start;
    logic   end_of_text;
    t_count total_matches;

    modport source (output valid, output match_valid, output match_start,
                    output end_of_text, output total_matches, input ready);
    modport sink   (input valid, input match_valid, input match_start,
                    input end_of_text, input total_matches, output ready);
endinterface

// ===== src/wpm_cell.sv =====
// ----------------------------------------------------------------------------
// wpm_cell
// One window slot: holds a text byte, passes it on each beat and compares
// the incoming byte against its assigned pattern character.
// ----------------------------------------------------------------------------
module wpm_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  wpm_pkg::t_byte i_byte,
    input  wpm_pkg::t_byte i_pattern_char,
    input  logic           i_wildcard,
    input  logic           i_active,
    output wpm_pkg::t_byte o_byte,
    output logic           o_hit
);
    import wpm_pkg::*;

    t_byte r_byte;

    // slots never reached by the current text are never compared, so no reset
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_active || (i_byte == i_pattern_char)
                    || (i_wildcard && (i_pattern_char == WILDCARD_CHAR));
endmodule

// ===== src/wpm_tracker.sv =====
// ----------------------------------------------------------------------------
// wpm_tracker
// Position, non-overlap bound and match count; registered result stage.
// ----------------------------------------------------------------------------
module wpm_tracker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wpm_pkg::t_step i_step,
    input  wpm_pkg::t_len  i_len,
    output logic           o_busy,
    wpm_out_if.source      o_result
);
    import wpm_pkg::*;

    localparam t_pos   POS_MAX   = '1;
    localparam t_count COUNT_MAX = '1;

    t_pos   r_pos, n_pos;
    t_pos   r_ens, n_ens;
    t_count r_count, n_count;

    logic   r_valid, n_valid;
    logic   r_match_valid;
    t_count r_match_start;
    logic   r_end_of_text;
    t_count r_total;

    logic   have_pos;
    logic   reach;
    t_pos   start;
    t_pos   len_ext;
    logic   hit;
    logic   emit;

    always_comb begin
        len_ext  = t_pos'(i_len);
        have_pos = (r_pos != POS_MAX);
        reach    = (r_pos >= len_ext - t_pos'(1));
        start    = r_pos + t_pos'(1) - len_ext;
        hit      = have_pos && reach && i_step.all_hit && (start >= r_ens);
        emit     = hit || i_step.last;

        n_pos   = have_pos ? r_pos + t_pos'(1) : r_pos;
        n_ens   = hit ? r_pos + t_pos'(1) : r_ens;
        n_count = (hit && (r_count != COUNT_MAX)) ? r_count + t_count'(1) : r_count;

        // a new beat loads the slot; otherwise it holds until taken
        n_valid = (i_step.accept && emit) || (r_valid && !o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ens   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_step.accept) begin
                if (i_step.last) begin
                    r_pos   <= '0;
                    r_ens   <= '0;
                    r_count <= '0;
                end else begin
                    r_pos   <= n_pos;
                    r_ens   <= n_ens;
                    r_count <= n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.accept && emit) begin
            r_match_valid <= hit;
            r_match_start <= hit ? t_count'(start) : '0;
            r_end_of_text <= i_step.last;
            r_total       <= n_count;
        end
    end

    // a held result blocks new beats only while the sink stalls it
    assign o_busy = r_valid && !o_result.ready;

    assign o_result.valid         = r_valid;
    assign o_result.match_valid   = r_match_valid;
    assign o_result.match_start   = r_match_start;
    assign o_result.end_of_text   = r_end_of_text;
    assign o_result.total_matches = r_total;
endmodule

// ===== src/wildcard_pattern_match_stream.sv =====
// ----------------------------------------------------------------------------
// wildcard_pattern_match_stream
// Result timing: a result is registered and shown in the cycle after the byte that causes it.
// Throughput: one text byte per cycle; the window is a chain of compare cells
// and a single output register, so input stalls only while a held result
// is itself stalled by the sink.
// Reset: synchronous, active low; registers return to their defaults
// (length 1, wildcard off) and the position, bound and count clear.
// ----------------------------------------------------------------------------
module wildcard_pattern_match_stream (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [wpm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [wpm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    wpm_in_if.sink                              i_text,
    wpm_out_if.source                           o_result
);
    import wpm_pkg::*;

    logic [CFG_DATA_BITS-1:0] r_pattern_low;
    logic [CFG_DATA_BITS-1:0] r_pattern_high;
    logic [4:0]               r_pattern_length;
    logic                     r_wildcard;

    t_len  eff_len;
    t_byte pattern_chars [MAX_PATTERN];
    t_byte cell_bytes    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hits;
    logic  busy;
    logic  accept;
    t_step step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_pattern_length <= 5'd1;
            r_wildcard       <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[4:0];
                CFG_WILDCARD:       r_wildcard       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign eff_len = effective_length(r_pattern_length);

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pattern_chars[k] = (k < 8) ? r_pattern_low[(k % 8) * 8 +: 8]
                                       : r_pattern_high[(k % 8) * 8 +: 8];
        end
    end

    assign i_text.ready = !busy;
    assign accept       = i_text.valid && i_text.ready;

    // slot j compares the byte j beats old against pattern char len-1-j
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic    active;
        t_len    pidx;
        t_byte   cell_in;

        assign active  = (t_len'(j) < eff_len);
        assign pidx    = eff_len - t_len'(j) - t_len'(1);
        assign cell_in = (j == 0) ? i_text.text_byte : cell_bytes[(j == 0) ? 0 : j - 1];

        wpm_cell u_cell (
            .i_clk          (i_clk),
            .i_shift        (accept),
            .i_byte         (cell_in),
            .i_pattern_char (pattern_chars[pidx[IDX_BITS-1:0]]),
            .i_wildcard     (r_wildcard),
            .i_active       (active),
            .o_byte         (cell_bytes[j]),
            .o_hit          (hits[j])
        );
    end

    assign step.accept  = accept;
    assign step.last    = i_text.last_byte;
    assign step.all_hit = &hits;

    wpm_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_len    (eff_len),
        .o_busy   (busy),
        .o_result (o_result)
    );
endmodule
